/* sv/sse_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted set engine package
// Shared constants, action codes and payload types of the sorted set engine.
// ----------------------------------------------------------------------------
package sse_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] ACT_ADD      = 2'd0;
    localparam logic [1:0] ACT_REMOVE   = 2'd1;
    localparam logic [1:0] ACT_CONTAINS = 2'd2;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [KEY_W-1:0] key;
    } t_cmd;

    typedef struct packed {
        logic success;
        logic full_res;
    } t_result;

    // Broadcast from the control logic to every cell.
    typedef struct packed {
        logic                    ins;
        logic                    rem;
        logic signed [KEY_W-1:0] key;
    } t_cell_ctl;

    // What a cell shows its right-hand neighbor.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    lt;
    } t_link;

endpackage

/* sv/sse_cell.sv */
// ----------------------------------------------------------------------------
// Sorted set cell
// Holds one key of the ordered chain, compares it with the broadcast key and
// shifts toward either neighbor on insert or remove.
// ----------------------------------------------------------------------------
module sse_cell (
    input  logic              i_clk,
    input  sse_pkg::t_cell_ctl i_ctl,
    input  logic              i_occ,
    input  sse_pkg::t_link    i_left,
    input  logic signed [sse_pkg::KEY_W-1:0] i_right_key,
    output sse_pkg::t_link    o_link,
    output logic              o_eq
);
    import sse_pkg::*;

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;
    logic                    w_lt;

    assign w_lt   = i_occ && (r_key < i_ctl.key);
    assign o_eq   = i_occ && (r_key == i_ctl.key);
    assign o_link = '{key: r_key, lt: w_lt};

    // Cells below the insert or remove position keep their key. On insert the
    // position cell takes the new key; the others from it up shift one place.
    always_comb begin
        n_key = r_key;
        if (!w_lt) begin
            if (i_ctl.ins) begin
                n_key = i_left.lt ? i_ctl.key : i_left.key;
            end else if (i_ctl.rem) begin
                n_key = i_right_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

/* sv/sorted_set_engine_unit.sv */
// ----------------------------------------------------------------------------
// Sorted set engine
// Keeps distinct signed keys in ascending order in a chain of compare cells.
// ----------------------------------------------------------------------------
// Usage:
//   A command (action and key) is transferred when start is high and busy is
//   low. Actions are add, remove and contains; the unused action code does
//   nothing and reports failure.
//   Every cell compares its key with the command key in the same cycle, so a
//   command is decided and the chain shifted in the cycle of its transfer.
//   Output: the result appears on o_result with o_valid high in the cycle
//   after the command transfer, and stays for that single cycle.
//   Throughput: one command per cycle; busy is never raised.
//   The result is transferred at the edge that ends its cycle; the receiver
//   has no way to stall it and must take it then.
//   An add to a set already holding CAPACITY keys fails with full_res set,
//   unless the key is already present.
//   Reset (synchronous, active low) empties the set and clears o_valid. The
//   key cells are not cleared; only cells below the key count are compared.
// ----------------------------------------------------------------------------
module sorted_set_engine_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  sse_pkg::t_cmd    i_cmd,
    output logic             o_valid,
    output sse_pkg::t_result o_result
);
    import sse_pkg::*;

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_valid;
    t_result                 r_result;
    t_result                 n_result;
    t_cell_ctl               w_ctl;
    t_link                   w_link [CAPACITY];
    t_link                   w_left [CAPACITY];
    logic signed [KEY_W-1:0] w_right_key [CAPACITY];
    logic [CAPACITY-1:0]     w_eq;
    logic [CAPACITY-1:0]     w_occ;
    logic                    w_accept;
    logic                    w_present;
    logic                    w_full;

    assign busy      = 1'b0;
    assign w_accept  = start && !busy;
    assign w_present = |w_eq;
    assign w_full    = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        w_ctl.key = i_cmd.key;
        w_ctl.ins = w_accept && (i_cmd.action == ACT_ADD) && !w_present && !w_full;
        w_ctl.rem = w_accept && (i_cmd.action == ACT_REMOVE) && w_present;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            assign w_occ[gi] = (CNT_W'(gi) < r_count);

            // The first cell sees a virtual left neighbor below every key.
            if (gi == 0) begin : g_first
                assign w_left[gi] = '{key: i_cmd.key, lt: 1'b1};
            end else begin : g_inner
                assign w_left[gi] = w_link[gi-1];
            end

            // The top cell's shift-in value on remove lands above the count.
            if (gi == CAPACITY - 1) begin : g_last
                assign w_right_key[gi] = i_cmd.key;
            end else begin : g_below
                assign w_right_key[gi] = w_link[gi+1].key;
            end

            sse_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_occ       (w_occ[gi]),
                .i_left      (w_left[gi]),
                .i_right_key (w_right_key[gi]),
                .o_link      (w_link[gi]),
                .o_eq        (w_eq[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_result = '{success: 1'b0, full_res: 1'b0};
        if (w_ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.rem) begin
            n_count = r_count - CNT_W'(1);
        end
        case (i_cmd.action)
            ACT_ADD: begin
                n_result.success  = !w_present && !w_full;
                n_result.full_res = !w_present && w_full;
            end
            ACT_REMOVE: begin
                n_result.success = w_present;
            end
            ACT_CONTAINS: begin
                n_result.success = w_present;
            end
            default: begin
                n_result = '{success: 1'b0, full_res: 1'b0};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* sv/sse_checker.sv */
// ----------------------------------------------------------------------------
// Sorted set engine checker
// Port-level timing and result checks, bound to the top level.
// ----------------------------------------------------------------------------
module sse_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input sse_pkg::t_cmd    i_cmd,
    input logic             o_valid,
    input sse_pkg::t_result o_result
);
    import sse_pkg::*;

    // Every command transfer gives exactly one result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("missing result after command transfer");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_valid)
        else $error("result without command transfer");

    a_full_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.full_res) |-> !o_result.success)
        else $error("full flag on a successful result");

    // A key just removed cannot be found by the next command.
    a_removed_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.action == ACT_CONTAINS) && $past(i_rst_n)
         && $past(start && !busy && (i_cmd.action == ACT_REMOVE))
         && (i_cmd.key == $past(i_cmd.key)))
        |=> (o_valid && !o_result.success))
        else $error("removed key still reported present");

endmodule

bind sorted_set_engine_unit sse_checker u_sse_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_valid  (o_valid),
    .o_result (o_result)
);
